// File: sv/pma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pma_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int IDX_BITS    = 4;
	localparam int WIN_BITS    = 16;
	localparam int VCNT_BITS   = 5;
	localparam int TOTAL_BITS  = 20;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_START_VERTEX = 1'b1;

	localparam logic [VCNT_BITS-1:0] VCNT_RESET  = 5'd16;
	localparam logic [IDX_BITS-1:0]  START_RESET = 4'd0;

endpackage

`default_nettype wire

// File: sv/prim_mst_adjacency_matrix_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Minimum spanning tree over an adjacency matrix (Prim's method).
// Input channel s_*: one matrix entry per item {weight, col, row}; weight 0 is
// no edge. Entries are written into the edge RAM one per cycle. The item with
// s_tlast set is stored and then starts the tree build from start_vertex over
// the first vertex_count vertices; s_tready stays low until the last result is
// loaded into the output register.
// A build for n vertices runs a setup step, then for each tree step a serial
// key scan over the n vertices and an edge-RAM relax pass, then a total pass;
// its length is set by the single read port of the edge RAM and the one shared
// key comparator.
// Output channel m_*: one item per vertex in ascending order, each read from the
// edge RAM and loaded into the output register; m_tlast marks the final vertex.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears the sequencer, tree state and output valid; vertex_count resets
// to 16 and start_vertex to 0. The edge RAM is not cleared: entries must be
// written before a build reads them. Configuration is written over APB.
module prim_mst_adjacency_matrix_unit
	import pma_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row[3:0], col[7:4], weight[23:8]
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,   // vertex[3:0], has_parent[4], parent[8:5],
	                                              // edge_weight[24:9], total_weight[44:25]
	output logic                       m_tlast
);

	logic [VCNT_BITS-1:0] vertex_count_q;
	logic [IDX_BITS-1:0]  start_vertex_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCNT_RESET;
			start_vertex_q <= START_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[VCNT_BITS-1:0];
				REG_START_VERTEX: start_vertex_q <= pwdata[IDX_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VERTEX_COUNT: prdata = APB_DW'(vertex_count_q);
			REG_START_VERTEX: prdata = APB_DW'(start_vertex_q);
			default:          prdata = '0;
		endcase
	end

	pma_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_count(vertex_count_q),
		.start_vertex(start_vertex_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

// File: sv/pma_edge_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pma_edge_ram #(
	parameter int AW = 8,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data_q
);

	logic [DW-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/pma_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

// shared key compare: take when enabled and a is strictly below b
module pma_cmp #(
	parameter int W = 17
) (
	input  wire logic         en,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              take
);

	always_comb begin
		take = en && (a < b);
	end

endmodule

`default_nettype wire

// File: sv/pma_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module pma_seq
	import pma_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VCNT_BITS-1:0]  vertex_count,
	input  wire logic [IDX_BITS-1:0]   start_vertex,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,
	output logic                       m_tlast
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int KW = WEIGHT_BITS + 1;
	localparam int AW = 2 * VW;
	localparam int SW = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;
	localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_RELAX,
		ST_SUM,
		ST_OUT_RD,
		ST_OUT_LD
	} st_t;

	st_t st_q;

	logic [KW-1:0]          key_q [MAX_VERTICES];
	logic [VW-1:0]          par_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] pv_q;
	logic [MAX_VERTICES-1:0] in_tree_q;

	logic [CW-1:0]         n_q;
	logic [VW-1:0]         s_q;
	logic [CW-1:0]         cnt_q;
	logic [VW-1:0]         v_q;
	logic [VW-1:0]         u_q;
	logic [KW-1:0]         best_q;
	logic                  have_q;
	logic                  iss_q;
	logic                  rv_s1;
	logic [VW-1:0]         rvx_s1;
	logic [TOTAL_BITS-1:0] tot_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tlast_q;

	logic [IDX_BITS-1:0]    in_row, in_col;
	logic [WIN_BITS-1:0]    in_weight;
	logic                   in_acc, row_ok, col_ok;
	logic [CW-1:0]          n_c;
	logic [VW-1:0]          s_c;
	logic                   wr_en, rd_en;
	logic [AW-1:0]          rd_addr;
	logic [WEIGHT_BITS-1:0] rd_data;
	logic [VW-1:0]          kidx;
	logic [KW-1:0]          key_rd;
	logic                   cmp_en, take;
	logic [KW-1:0]          cmp_a, cmp_b;
	logic                   v_last;
	logic [VW-1:0]          u_n;
	logic [SW-1:0]          sum_w;
	logic                   slot_free;
	logic                   hp;

	assign in_row    = s_tdata[3:0];
	assign in_col    = s_tdata[7:4];
	assign in_weight = s_tdata[23:8];
	assign s_tready  = (st_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign row_ok    = int'(in_row) < MAX_VERTICES;
	assign col_ok    = int'(in_col) < MAX_VERTICES;
	assign wr_en     = in_acc && row_ok && col_ok;

	always_comb begin
		if (vertex_count == '0) begin
			n_c = CW'(1);
		end else if (int'(vertex_count) > MAX_VERTICES) begin
			n_c = CW'(MAX_VERTICES);
		end else begin
			n_c = CW'(vertex_count);
		end
		if (int'(start_vertex) >= int'(n_c)) begin
			s_c = VW'(n_c - CW'(1));
		end else begin
			s_c = VW'(start_vertex);
		end
	end

	assign rd_en   = ((st_q == ST_RELAX || st_q == ST_SUM) && iss_q) || (st_q == ST_OUT_RD);
	assign rd_addr = (st_q == ST_RELAX) ? {u_q, v_q} : {v_q, par_q[v_q]};

	pma_edge_ram #(
		.AW(AW),
		.DW(WEIGHT_BITS)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  ({VW'(in_row), VW'(in_col)}),
		.wr_data  (WEIGHT_BITS'(in_weight)),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data_q(rd_data)
	);

	assign kidx   = (st_q == ST_RELAX) ? rvx_s1 : v_q;
	assign key_rd = key_q[kidx];

	always_comb begin
		cmp_en = 1'b0;
		cmp_a  = key_rd;
		cmp_b  = best_q;
		if (st_q == ST_SCAN) begin
			cmp_en = !in_tree_q[v_q];
		end else if (st_q == ST_RELAX) begin
			cmp_en = rv_s1 && (rd_data != '0) && !in_tree_q[rvx_s1];
			cmp_a  = KW'(rd_data);
			cmp_b  = key_rd;
		end
	end

	pma_cmp #(
		.W(KW)
	) u_cmp (
		.en  (cmp_en),
		.a   (cmp_a),
		.b   (cmp_b),
		.take(take)
	);

	assign v_last    = (CW'(v_q) == n_q - CW'(1));
	assign u_n       = take ? v_q : u_q;
	assign sum_w     = SW'(tot_q) + SW'(rd_data);
	assign slot_free = !m_tvalid_q || m_tready;
	assign hp        = pv_q[v_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				key_q[i] <= KEY_INF;
				par_q[i] <= '0;
			end
			pv_q       <= '0;
			in_tree_q  <= '0;
			n_q        <= CW'(1);
			s_q        <= '0;
			cnt_q      <= '0;
			v_q        <= '0;
			u_q        <= '0;
			best_q     <= KEY_INF;
			have_q     <= 1'b0;
			iss_q      <= 1'b0;
			rv_s1      <= 1'b0;
			rvx_s1     <= '0;
			tot_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && s_tlast) begin
						n_q  <= n_c;
						s_q  <= s_c;
						st_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					for (int i = 0; i < MAX_VERTICES; i++) begin
						key_q[i] <= KEY_INF;
						par_q[i] <= '0;
					end
					key_q[s_q] <= '0;
					pv_q       <= '0;
					in_tree_q  <= '0;
					cnt_q      <= '0;
					v_q        <= '0;
					best_q     <= KEY_INF;
					have_q     <= 1'b0;
					iss_q      <= 1'b1;
					rv_s1      <= 1'b0;
					tot_q      <= '0;
					st_q       <= (n_q == CW'(1)) ? ST_SUM : ST_SCAN;
				end
				ST_SCAN: begin
					if (take) begin
						best_q <= key_rd;
						u_q    <= v_q;
						have_q <= 1'b1;
					end
					if (v_last) begin
						v_q   <= '0;
						iss_q <= 1'b1;
						rv_s1 <= 1'b0;
						if (have_q || take) begin
							in_tree_q[u_n] <= 1'b1;
							u_q            <= u_n;
							st_q           <= ST_RELAX;
						end else begin
							tot_q <= '0;
							st_q  <= ST_SUM;
						end
					end else begin
						v_q <= v_q + VW'(1);
					end
				end
				ST_RELAX: begin
					rv_s1  <= iss_q;
					rvx_s1 <= v_q;
					if (iss_q) begin
						if (v_last) begin
							iss_q <= 1'b0;
						end else begin
							v_q <= v_q + VW'(1);
						end
					end
					if (take) begin
						key_q[rvx_s1] <= KW'(rd_data);
						par_q[rvx_s1] <= u_q;
						pv_q[rvx_s1]  <= 1'b1;
					end
					if (rv_s1 && !iss_q) begin
						rv_s1 <= 1'b0;
						v_q   <= '0;
						iss_q <= 1'b1;
						if (({1'b0, cnt_q} + (CW + 1)'(2)) < {1'b0, n_q}) begin
							cnt_q  <= cnt_q + CW'(1);
							best_q <= KEY_INF;
							have_q <= 1'b0;
							st_q   <= ST_SCAN;
						end else begin
							tot_q <= '0;
							st_q  <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					rv_s1  <= iss_q;
					rvx_s1 <= v_q;
					if (iss_q) begin
						if (v_last) begin
							iss_q <= 1'b0;
						end else begin
							v_q <= v_q + VW'(1);
						end
					end
					if (rv_s1 && pv_q[rvx_s1]) begin
						tot_q <= (sum_w > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum_w);
					end
					if (rv_s1 && !iss_q) begin
						rv_s1 <= 1'b0;
						v_q   <= '0;
						st_q  <= ST_OUT_RD;
					end
				end
				ST_OUT_RD: begin
					st_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= v_last;
						m_tdata_q  <= {3'b000, tot_q,
							hp ? WIN_BITS'(rd_data) : WIN_BITS'(0),
							hp ? IDX_BITS'(par_q[v_q]) : IDX_BITS'(0),
							hp, IDX_BITS'(v_q)};
						if (v_last) begin
							st_q <= ST_IDLE;
						end else begin
							v_q  <= v_q + VW'(1);
							st_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_relax_root_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RELAX) |-> in_tree_q[u_q])
		else $error("relax vertex not in tree");

	a_read_pipe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (st_q == ST_RELAX || st_q == ST_SUM))
		else $error("read pipeline active outside relax or sum");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (CW'(v_q) < n_q))
		else $error("scan index beyond vertex count");

	a_output_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT_LD && slot_free) |=> m_tvalid_q)
		else $error("result not presented after load");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pma_pkg::*;

	localparam int ITEM_TARGET    = 460;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 32;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {GR_RANDOM, GR_TIES, GR_HEAVY, GR_CUT} graph_style_t;

	typedef struct {
		logic [IDX_BITS-1:0]   vertex;
		logic                  has_parent;
		logic [IDX_BITS-1:0]   parent;
		logic [WIN_BITS-1:0]   edge_weight;
		logic [TOTAL_BITS-1:0] total;
		logic                  is_last;
	} vertex_result_t;

	class mst_scoreboard;
		localparam int NV = MAX_VERTICES_DEF;
		localparam logic [WIN_BITS:0] KEY_INF = 1 << WIN_BITS;

		logic [WIN_BITS-1:0]  edge_w [NV][NV];
		logic [VCNT_BITS-1:0] vcount;
		logic [IDX_BITS-1:0]  start;
		vertex_result_t       tree_results [$];
		int                   errors;
		int                   builds;
		int                   results;

		function new();
			foreach (edge_w[r, c])
				edge_w[r][c] = '0;
			vcount  = VCNT_RESET;
			start   = START_RESET;
			errors  = 0;
			builds  = 0;
			results = 0;
		endfunction

		function int unsigned active_count();
			if (vcount == 0)
				return 1;
			if (vcount > NV)
				return NV;
			return 32'(vcount);
		endfunction

		function int pending();
			return tree_results.size();
		endfunction

		function void grow_tree();
			int unsigned       n;
			int unsigned       s;
			int unsigned       u;
			int unsigned       sum;
			int                pick;
			logic [WIN_BITS:0] best;
			logic [WIN_BITS:0] key [NV];
			int unsigned       par [NV];
			bit                linked [NV];
			bit                placed [NV];
			vertex_result_t    r;
			n = active_count();
			s = 32'(start);
			if (s >= n)
				s = n - 1;
			for (int v = 0; v < NV; v++) begin
				key[v]    = KEY_INF;
				par[v]    = 0;
				linked[v] = 1'b0;
				placed[v] = 1'b0;
			end
			key[s] = '0;
			for (int step = 0; step + 1 < n; step++) begin
				best = KEY_INF;
				pick = -1;
				for (int v = 0; v < n; v++) begin
					if (!placed[v] && key[v] < best) begin
						best = key[v];
						pick = v;
					end
				end
				if (pick < 0)
					break;
				u = pick;
				placed[u] = 1'b1;
				for (int v = 0; v < n; v++) begin
					if (edge_w[u][v] != 0 && !placed[v] && {1'b0, edge_w[u][v]} < key[v]) begin
						par[v]    = u;
						linked[v] = 1'b1;
						key[v]    = {1'b0, edge_w[u][v]};
					end
				end
			end
			sum = 0;
			for (int v = 0; v < n; v++)
				if (linked[v])
					sum += 32'(edge_w[v][par[v]]);
			if (sum > 32'(TOTAL_MAX))
				sum = 32'(TOTAL_MAX);
			for (int v = 0; v < n; v++) begin
				r.vertex      = IDX_BITS'(v);
				r.has_parent  = linked[v];
				r.parent      = linked[v] ? IDX_BITS'(par[v]) : '0;
				r.edge_weight = linked[v] ? edge_w[v][par[v]] : '0;
				r.total       = TOTAL_BITS'(sum);
				r.is_last     = (v + 1 == n);
				tree_results.push_back(r);
			end
			builds++;
		endfunction

		function void note_entry(input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c,
				input logic [WIN_BITS-1:0] w, input logic tail);
			edge_w[r][c] = w;
			if (tail)
				grow_tree();
		endfunction

		task report(input string what, input logic [OUT_DATA_W-1:0] got,
				input logic [OUT_DATA_W-1:0] want);
			$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
				results, what, got, want);
			errors++;
		endtask

		task check_result(input logic [OUT_DATA_W-1:0] data, input logic tail);
			vertex_result_t want;
			if (tree_results.size() == 0) begin
				report("item with nothing expected", data, '0);
				return;
			end
			want = tree_results.pop_front();
			results++;
			if (data[3:0] !== want.vertex)
				report("vertex", OUT_DATA_W'(data[3:0]), OUT_DATA_W'(want.vertex));
			if (data[4] !== want.has_parent)
				report("has_parent", OUT_DATA_W'(data[4]), OUT_DATA_W'(want.has_parent));
			if (data[8:5] !== want.parent)
				report("parent", OUT_DATA_W'(data[8:5]), OUT_DATA_W'(want.parent));
			if (data[24:9] !== want.edge_weight)
				report("edge_weight", OUT_DATA_W'(data[24:9]), OUT_DATA_W'(want.edge_weight));
			if (data[44:25] !== want.total)
				report("total_weight", OUT_DATA_W'(data[44:25]), OUT_DATA_W'(want.total));
			if (data[47:45] !== 3'b000)
				report("pad bits", OUT_DATA_W'(data[47:45]), '0);
			if (tail !== want.is_last)
				report("m_tlast", OUT_DATA_W'(tail), OUT_DATA_W'(want.is_last));
		endtask
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_AW-1:0]     paddr    = '0;
	logic [APB_DW-1:0]     pwdata   = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // row[3:0], col[7:4], weight[23:8]
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // vertex[3:0], has_parent[4], parent[8:5],
	                                        // edge_weight[24:9], total_weight[44:25]
	logic                  m_tlast;

	mst_scoreboard sb = new();
	bit written [MAX_VERTICES_DEF][MAX_VERTICES_DEF];
	int items_sent   = 0;
	int hold_cycles  = 0;
	int stall_cycles = 0;
	bit tx_quiet     = 1'b0;
	bit rx_quiet     = 1'b0;

	prim_mst_adjacency_matrix_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_entry(s_tdata[3:0], s_tdata[7:4], s_tdata[23:8], s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", stall_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: per-item random stall, quiet stretches, one long hold on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 5);
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if ($urandom_range(0, 15) == 0)
				rx_quiet = !rx_quiet;
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_VERTEX_COUNT: sb.vcount = value[VCNT_BITS-1:0];
			REG_START_VERTEX: sb.start  = value[IDX_BITS-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_entry(input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c,
			input logic [WIN_BITS-1:0] w, input logic tail);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {w, c, r};
		s_tlast  <= tail;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		written[r][c] = 1'b1;
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [VCNT_BITS-1:0] count, input logic [IDX_BITS-1:0] root);
		drain();
		apb_write(REG_VERTEX_COUNT, APB_DW'(count));
		apb_write(REG_START_VERTEX, APB_DW'(root));
	endtask

	function automatic logic [WIN_BITS-1:0] pick_weight(input graph_style_t style);
		int p;
		p = $urandom_range(0, 99);
		case (style)
			GR_TIES: begin
				return (p < 30) ? '0 : ((p < 65) ? WIN_BITS'(1) : WIN_BITS'(2));
			end
			GR_HEAVY: begin
				if (p < 10)
					return '0;
				return (p < 60) ? '1 : WIN_BITS'($urandom_range(16'hF000, 16'hFFFE));
			end
			default: begin
				if (p < 35)
					return '0;
				if (p < 50)
					return WIN_BITS'($urandom_range(1, 3));
				if (p < 60)
					return '1;
				return WIN_BITS'($urandom);
			end
		endcase
	endfunction

	function automatic logic [VCNT_BITS-1:0] pick_count();
		int p;
		p = $urandom_range(0, 9);
		case (p)
			0: return '0;
			1: return VCNT_BITS'($urandom_range(17, 31));
			2: return VCNT_BITS'(1);
			3: return VCNT_BITS'(16);
			default: return VCNT_BITS'($urandom_range(2, 8));
		endcase
	endfunction

	// every entry of the active square is written before the build reads it
	task automatic build_graph(input graph_style_t style);
		int n;
		int r;
		int c;
		int extra;
		int cut;
		logic [WIN_BITS-1:0] w;
		n = sb.active_count();
		cut = $urandom_range(0, n - 1);
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				if (!written[r][c])
					send_entry(IDX_BITS'(r), IDX_BITS'(c), pick_weight(style), 1'b0);
		extra = $urandom_range(1, 2 * n);
		for (int k = 0; k < extra; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(0, 15);
				c = $urandom_range(0, 15);
			end else begin
				r = $urandom_range(0, n - 1);
				c = $urandom_range(0, n - 1);
			end
			w = pick_weight(style);
			send_entry(IDX_BITS'(r), IDX_BITS'(c), w, 1'b0);
			if ($urandom_range(0, 1) != 0)
				send_entry(IDX_BITS'(c), IDX_BITS'(r), w, 1'b0);
		end
		if (style == GR_CUT) begin
			for (c = 0; c < n; c++) begin
				send_entry(IDX_BITS'(cut), IDX_BITS'(c), '0, 1'b0);
				send_entry(IDX_BITS'(c), IDX_BITS'(cut), '0, 1'b0);
			end
		end
		r = $urandom_range(0, n - 1);
		c = $urandom_range(0, n - 1);
		w = (style == GR_CUT) ? '0 : pick_weight(style);
		send_entry(IDX_BITS'(r), IDX_BITS'(c), w, 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex, then count zero with root beyond the count
		set_config(5'd1, 4'd0);
		send_entry(4'd0, 4'd0, 16'hFFFF, 1'b1);
		set_config(5'd0, 4'd15);
		send_entry(4'd0, 4'd0, 16'h0000, 1'b1);

		// two vertices, root clamped to 1, heaviest edge
		set_config(5'd2, 4'd15);
		send_entry(4'd0, 4'd1, 16'hFFFF, 1'b0);
		send_entry(4'd1, 4'd0, 16'hFFFF, 1'b0);
		send_entry(4'd1, 4'd1, 16'h0000, 1'b1);

		// vertex 1 cut off from the tree
		set_config(5'd3, 4'd0);
		send_entry(4'd0, 4'd1, 16'h0000, 1'b0);
		send_entry(4'd1, 4'd0, 16'h0000, 1'b0);
		send_entry(4'd0, 4'd2, 16'h0001, 1'b0);
		send_entry(4'd2, 4'd0, 16'h0001, 1'b0);
		send_entry(4'd1, 4'd2, 16'h0000, 1'b0);
		send_entry(4'd2, 4'd1, 16'h0000, 1'b0);
		send_entry(4'd2, 4'd2, 16'h0000, 1'b1);

		// all edges equal: the scan takes the lowest index on a tie, a relax tie keeps the earlier parent
		set_config(5'd3, 4'd2);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_entry(IDX_BITS'(r), IDX_BITS'(c), (r == c) ? 16'h0000 : 16'h0007,
					(r == 2 && c == 2));

		for (int bi = 0; items_sent < ITEM_TARGET; bi++) begin
			if (bi == 0)
				set_config(5'd31, IDX_BITS'($urandom_range(0, 15)));
			else if (bi == 1)
				set_config(VCNT_BITS'(16), IDX_BITS'($urandom_range(0, 15)));
			else if (bi != 2 && $urandom_range(0, 2) != 0)
				set_config(pick_count(), IDX_BITS'($urandom_range(0, 15)));
			else if (bi == 3 || (bi != 2 && $urandom_range(0, 4) == 0))
				drain();
			if (bi == 1)
				hold_cycles = HOLD_CYCLES;
			tx_quiet = ($urandom_range(0, 3) == 0);
			build_graph((bi < 2) ? GR_RANDOM : graph_style_t'($urandom_range(0, 3)));
		end

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("results never delivered", OUT_DATA_W'(sb.pending()), '0);
		$display("covered %0d matrix entries, %0d tree builds, %0d vertex results checked",
			items_sent, sb.builds, sb.results);
		$display("counts 0 to 31, roots past the count, ties, cut vertices, output hold-off");
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
sv/pma_pkg.sv
sv/pma_edge_ram.sv
sv/pma_cmp.sv
sv/pma_seq.sv
sv/prim_mst_adjacency_matrix_unit.sv
tb/tb_top.sv
